FILE: hw/rtl/tdf_pkg.sv
package tdf_pkg;

    localparam int VALUE_BITS = 31;
    // Trial divisors stay at or below the square root of the value range, plus one.
    localparam int DIV_BITS   = (VALUE_BITS + 2) / 2;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } tdf_state_t;

    typedef struct packed {
        logic load;       // take a new request into the remainder
        logic div_start;  // start remainder / divisor
        logic take_quot;  // remainder becomes the quotient
        logic incr;       // next trial divisor
        logic emit;       // write the output register
        logic emit_rem;   // emit the remainder (last) instead of the divisor
    } tdf_cmd_t;

    typedef struct packed {
        logic below_two;  // remainder is 0 or 1
        logic div_busy;
        logic stop;       // divisor exceeds the quotient
        logic exact;      // divisor divides the remainder
        logic out_free;
    } tdf_status_t;

endpackage

FILE: hw/rtl/tdf_ctrl.sv
module tdf_ctrl
    import tdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tdf_status_t status,
    output tdf_cmd_t    cmd
);

    tdf_state_t state_reg, state_next;
    logic       final_reg, final_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.below_two) begin
                    final_next = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    if (status.stop) begin
                        final_next = 1'b1;
                        state_next = ST_EMIT;
                    end else if (status.exact) begin
                        final_next = 1'b0;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.incr   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_rem = final_reg;
                    // After a found factor the quotient carries on as the remainder.
                    cmd.take_quot = !final_reg;
                    state_next    = final_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/tdf_datapath.sv
module tdf_datapath
    import tdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_BITS-1:0] in_value,
    input  tdf_cmd_t              cmd,
    output tdf_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] out_factor,
    output logic                  out_last
);

    logic [VALUE_BITS-1:0] rem_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [DIV_BITS-1:0]   part_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] factor_reg;
    logic                  last_reg;

    logic [DIV_BITS:0]     shifted;
    logic [DIV_BITS:0]     diff;
    logic                  fits;

    // Restoring divider: one quotient bit per cycle.
    assign shifted = {part_reg, quot_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= CNT_BITS'(VALUE_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            part_reg <= '0;
            quot_reg <= rem_reg;
        end else if (cnt_reg != '0) begin
            part_reg <= fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
            quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            div_reg <= DIV_BITS'(2);
        end else if (cmd.load) begin
            rem_reg <= in_value;
            div_reg <= DIV_BITS'(2);
        end else begin
            if (cmd.take_quot) begin
                rem_reg <= quot_reg;
            end
            if (cmd.incr) begin
                div_reg <= div_reg + DIV_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            factor_reg <= cmd.emit_rem ? rem_reg : VALUE_BITS'(div_reg);
            last_reg   <= cmd.emit_rem;
        end
    end

    assign status.below_two = (rem_reg[VALUE_BITS-1:1] == '0);
    assign status.div_busy  = (cnt_reg != '0);
    assign status.stop      = (VALUE_BITS'(div_reg) > quot_reg);
    assign status.exact     = (part_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_factor = factor_reg;
    assign out_last   = last_reg;

endmodule

FILE: hw/rtl/trial_division_factorizer_core.sv
// Channel  Direction  Payload
// s_       in         tdata: value [30:0]
// m_       out        tdata: factor [30:0]; tlast: last factor of the request
//
// Each trial division runs the restoring divider, which produces one quotient bit
// per cycle. A request tries each trial divisor up to the square root of the
// value; a divisor that divides it is emitted and then tried again on the quotient.
// Synchronous active-low reset clears the controller, remainder, divider count
// and valid, and sets the divisor to 2.
// A full result register stalls the search at the next factor; one request at a time.
module trial_division_factorizer_core
    import tdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,  // [30:0] value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,  // [30:0] factor
    output logic                  m_tlast
);

    tdf_cmd_t              cmd;
    tdf_status_t           status;
    logic [VALUE_BITS-1:0] factor;

    tdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdf_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_value   (s_tdata[VALUE_BITS-1:0]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_factor (factor),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDATA_BITS'(factor);

endmodule

FILE: hw/rtl/tdf_checker.sv
module tdf_checker
    import tdf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Requests are worked one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // Zero and one only come back as a lone, final result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[VALUE_BITS-1:1] == '0) |-> m_tlast)
        else $error("factor below two not marked last");

    // The next request is taken only after the last factor has been produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken before last factor");

endmodule

bind trial_division_factorizer_core tdf_checker u_tdf_checker (.*);
